// File: sv/tlh_pkg.sv
// ----------------------------------------------------------------------------
// tlh_pkg
// shared types and constants of the text line history core
// ----------------------------------------------------------------------------
package tlh_pkg;

	// operation codes
	localparam logic [1:0] OP_SYMBOL = 2'd0;
	localparam logic [1:0] OP_LETTER = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// symbol characters accepted by a symbol push
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_DASH = 8'h2D;

	localparam logic [31:0] VERSION_RESET = 32'd1;

	// widest line number, ring position and newest pointer over the parameter range
	localparam int LINE_NUM_W = 5;
	localparam int RING_POS_W = 8;
	localparam int NEWEST_W   = 4;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} tlh_state_t;

	// line descriptor update, one per executed push
	typedef struct packed {
		logic                  wr;
		logic [LINE_NUM_W-1:0] line;
		logic [RING_POS_W-1:0] len;
		logic [RING_POS_W-1:0] start;
		logic                  set_newest;
		logic                  side;
		logic [NEWEST_W-1:0]   newest;
	} tlh_meta_upd_t;

endpackage

// File: sv/two_channel_text_line_history_core.sv
// ----------------------------------------------------------------------------
// two_channel_text_line_history_core
// rotating text line history for the transmit and receive sides
// ----------------------------------------------------------------------------
// usage
//  input channel  in_valid / in_ready carries one operation beat: op, side,
//    char_in, line_index, char_pos
//  output channel out_valid / out_ready carries one result beat per input
//    beat: accepted, char_out, line_length, version_out
//  an accepted beat is captured, then executed in the execute state against
//    the line descriptors and the single-port character ram
//  pushes: the result is registered in the output register when the push executes
//  reads: the character comes from the registered ram read, so the result
//    is presented once that ram register holds it
//  a new beat is taken only once the last one has executed, as the sequencer
//    steps between capture and execute around the one ram port
//  the result sits in an output register, so the next input beat is taken
//    while a result waits; execution stalls only when that register is full
//    and out_ready is low
//  reset: all line lengths and ring starts cleared, newest pointers 0,
//    version 1; the character ram is not cleared (unread until written)
// ----------------------------------------------------------------------------
module two_channel_text_line_history_core #(
	parameter int LINE_CHARS     = 32,
	parameter int LINES_PER_SIDE = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        side,
	input  logic [7:0]  char_in,
	input  logic [1:0]  line_index,
	input  logic [4:0]  char_pos,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [7:0]  char_out,
	output logic [4:0]  line_length,
	output logic [31:0] version_out
);

	localparam int TOTAL_LINES = 2 * LINES_PER_SIDE;
	localparam int LW          = $clog2(TOTAL_LINES);
	localparam int NW          = $clog2(LINES_PER_SIDE);
	localparam int CW          = $clog2(LINE_CHARS);
	localparam int CAP         = LINE_CHARS - 1;
	localparam int DEPTH       = TOTAL_LINES * LINE_CHARS;
	localparam int AW          = $clog2(DEPTH);
	localparam int SW          = ((NW > 2) ? NW : 2) + 1;
	localparam int PW          = (CW > 5) ? CW : 5;

	// sequencer
	tlh_pkg::tlh_state_t state_q, state_d;
	logic in_acc;
	logic exec_go;

	// captured beat
	logic [1:0] op_s1;
	logic       side_s1;
	logic [7:0] ch_s1;
	logic [1:0] lidx_s1;
	logic [4:0] pos_s1;

	// line selection
	logic [NW-1:0] newest_tx, newest_rx, newest;
	logic [SW-1:0] n_sum, n_wrap;
	logic [NW-1:0] n_line;
	logic [LW-1:0] ln;
	logic          lidx_ok;

	// descriptor of the selected line
	logic [CW-1:0] len_rd, start_rd;
	logic          full;
	logic [CW:0]   app_sum, rd_sum, inc_sum;
	logic [CW-1:0] app_slot, rd_slot, inc_slot;
	logic [PW-1:0] pos_w, len_w;
	logic          hit;

	// execute results
	logic          push_ok;
	logic [CW-1:0] slot;
	logic [CW-1:0] len_new, start_new;
	logic [AW-1:0] ram_addr;
	logic          ram_we, ram_re;
	logic [7:0]    ram_rdata;
	tlh_pkg::tlh_meta_upd_t upd;
	logic [31:0]   version_q, version_inc, version_next;

	// read completion and output register
	logic       rd_s2;
	logic       hit_s2;
	logic       out_valid_q;
	logic       acc_q;
	logic [7:0] char_q;
	logic [4:0] len_q;
	logic [31:0] ver_q;

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// execute waits only while an untaken result holds the output register
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		exec_go  = 1'b0;
		unique case (state_q)
			tlh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = tlh_pkg::ST_EXEC;
				end
			end
			tlh_pkg::ST_EXEC: begin
				exec_go = !out_valid_q || out_ready;
				if (exec_go) begin
					state_d = tlh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlh_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_acc = in_valid && in_ready;

	// capture of the input beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op;
			side_s1 <= side;
			ch_s1   <= char_in;
			lidx_s1 <= line_index;
			pos_s1  <= char_pos;
		end
	end

	// ---------------------------------------------------------------- line selection
	assign newest = side_s1 ? newest_rx : newest_tx;

	// letter push moves to the next line, read looks ahead by line_index
	always_comb begin
		priority if (op_s1 == tlh_pkg::OP_LETTER) begin
			n_sum = SW'(newest) + SW'(1);
		end else if (op_s1 == tlh_pkg::OP_READ) begin
			n_sum = SW'(newest) + SW'(lidx_s1);
		end else begin
			n_sum = SW'(newest);
		end
	end

	assign n_wrap  = (n_sum >= SW'(LINES_PER_SIDE)) ? n_sum - SW'(LINES_PER_SIDE) : n_sum;
	assign n_line  = n_wrap[NW-1:0];
	assign ln      = side_s1 ? LW'(LINES_PER_SIDE) + LW'(n_line) : LW'(n_line);
	assign lidx_ok = SW'(lidx_s1) < SW'(LINES_PER_SIDE);

	tlh_line_meta #(
		.LINE_CHARS     (LINE_CHARS),
		.LINES_PER_SIDE (LINES_PER_SIDE)
	) u_meta (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.rd_line   (ln),
		.rd_len    (len_rd),
		.rd_start  (start_rd),
		.newest_tx (newest_tx),
		.newest_rx (newest_rx)
	);

	// ---------------------------------------------------------------- ring arithmetic
	// every sum stays below twice the capacity, so one subtract wraps it
	assign full     = (len_rd == CW'(CAP));
	assign app_sum  = (CW+1)'(start_rd) + (CW+1)'(len_rd);
	assign app_slot = (app_sum >= (CW+1)'(CAP)) ? CW'(app_sum - (CW+1)'(CAP)) : CW'(app_sum);
	assign inc_sum  = (CW+1)'(start_rd) + (CW+1)'(1);
	assign inc_slot = (inc_sum >= (CW+1)'(CAP)) ? CW'(inc_sum - (CW+1)'(CAP)) : CW'(inc_sum);

	assign pos_w    = PW'(pos_s1);
	assign len_w    = PW'(len_rd);
	assign hit      = lidx_ok && (pos_w < len_w);
	assign rd_sum   = (CW+1)'(start_rd) + (CW+1)'(pos_w[CW-1:0]);
	assign rd_slot  = (rd_sum >= (CW+1)'(CAP)) ? CW'(rd_sum - (CW+1)'(CAP)) : CW'(rd_sum);

	// ---------------------------------------------------------------- execute
	always_comb begin
		push_ok   = 1'b0;
		slot      = '0;
		len_new   = len_rd;
		start_new = start_rd;
		unique case (op_s1)
			tlh_pkg::OP_SYMBOL: begin
				push_ok = (ch_s1 == tlh_pkg::CH_DOT) || (ch_s1 == tlh_pkg::CH_DASH);
				// full line: overwrite the oldest slot and move the ring start
				if (full) begin
					slot      = start_rd;
					start_new = inc_slot;
				end else begin
					slot    = app_slot;
					len_new = len_rd + CW'(1);
				end
			end
			tlh_pkg::OP_LETTER: begin
				// fresh line holding the letter alone
				push_ok   = (ch_s1 != 8'd0);
				slot      = '0;
				len_new   = CW'(1);
				start_new = '0;
			end
			tlh_pkg::OP_READ: begin
				slot = rd_slot;
			end
			default: begin
				slot = '0;
			end
		endcase
	end

	assign ram_addr = AW'(ln) * AW'(LINE_CHARS) + AW'(slot);
	assign ram_we   = exec_go && push_ok;
	assign ram_re   = exec_go && (op_s1 == tlh_pkg::OP_READ) && hit;

	always_comb begin
		upd            = '0;
		upd.wr         = ram_we;
		upd.line       = tlh_pkg::LINE_NUM_W'(ln);
		upd.len        = tlh_pkg::RING_POS_W'(len_new);
		upd.start      = tlh_pkg::RING_POS_W'(start_new);
		upd.set_newest = ram_we && (op_s1 == tlh_pkg::OP_LETTER);
		upd.side       = side_s1;
		upd.newest     = tlh_pkg::NEWEST_W'(n_line);
	end

	tlh_line_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ch_s1),
		.rdata (ram_rdata)
	);

	// version skips zero on wrap
	assign version_inc  = version_q + 32'd1;
	assign version_next = (version_inc == 32'd0) ? tlh_pkg::VERSION_RESET : version_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= tlh_pkg::VERSION_RESET;
		end else if (ram_we) begin
			version_q <= version_next;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_s2       <= 1'b0;
		end else begin
			rd_s2 <= exec_go && (op_s1 == tlh_pkg::OP_READ);
			if (rd_s2) begin
				out_valid_q <= 1'b1;
			end else if (exec_go) begin
				// read results wait for the registered ram data
				out_valid_q <= (op_s1 != tlh_pkg::OP_READ);
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			hit_s2 <= hit;
			ver_q  <= push_ok ? version_next : version_q;
			char_q <= 8'd0;
			if (op_s1 == tlh_pkg::OP_READ) begin
				acc_q <= 1'b1;
				len_q <= lidx_ok ? 5'(len_rd) : 5'd0;
			end else begin
				acc_q <= push_ok;
				len_q <= 5'd0;
			end
		end else if (rd_s2) begin
			char_q <= hit_s2 ? ram_rdata : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = acc_q;
	assign char_out    = char_q;
	assign line_length = len_q;
	assign version_out = ver_q;

	// ---------------------------------------------------------------- assertions
	// a read completion never lands on a result still waiting
	a_rd_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s2 |-> !out_valid_q)
		else $error("read completion while output register busy");

	// the version counter never holds zero
	a_version_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		version_q != 32'd0)
		else $error("version counter is zero");

	// every stored push moves the version on
	a_push_bumps: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (version_q != $past(version_q)))
		else $error("stored push did not change version");

	// ram port is never asked for a write and a read together
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ram write and read in one cycle");

endmodule

// File: sv/tlh_line_ram.sv
// ----------------------------------------------------------------------------
// tlh_line_ram
// single-port character store with registered read
// ----------------------------------------------------------------------------
module tlh_line_ram #(
	parameter int DEPTH = 192,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: sv/tlh_line_meta.sv
// ----------------------------------------------------------------------------
// tlh_line_meta
// per-line length and ring start, per-side newest line pointer
// ----------------------------------------------------------------------------
module tlh_line_meta #(
	parameter int LINE_CHARS     = 32,
	parameter int LINES_PER_SIDE = 3,
	parameter int TOTAL_LINES    = 2 * LINES_PER_SIDE,
	parameter int LW             = $clog2(TOTAL_LINES),
	parameter int NW             = $clog2(LINES_PER_SIDE),
	parameter int CW             = $clog2(LINE_CHARS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tlh_pkg::tlh_meta_upd_t upd,
	input  logic [LW-1:0]         rd_line,
	output logic [CW-1:0]         rd_len,
	output logic [CW-1:0]         rd_start,
	output logic [NW-1:0]         newest_tx,
	output logic [NW-1:0]         newest_rx
);

	logic [CW-1:0] len_q    [TOTAL_LINES];
	logic [CW-1:0] start_q  [TOTAL_LINES];
	logic [NW-1:0] newest_q [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LINES; i++) begin
				len_q[i]   <= '0;
				start_q[i] <= '0;
			end
			newest_q[0] <= '0;
			newest_q[1] <= '0;
		end else begin
			if (upd.wr) begin
				len_q[upd.line[LW-1:0]]   <= upd.len[CW-1:0];
				start_q[upd.line[LW-1:0]] <= upd.start[CW-1:0];
			end
			if (upd.set_newest) begin
				newest_q[upd.side] <= upd.newest[NW-1:0];
			end
		end
	end

	assign rd_len    = len_q[rd_line];
	assign rd_start  = start_q[rd_line];
	assign newest_tx = newest_q[0];
	assign newest_rx = newest_q[1];

endmodule
